// ----- hdl/btxq_pkg.sv -----
// ============================================================================
// btxq_pkg
// Shared types and constants of the binary trie multiset with XOR queries.
// ============================================================================
`default_nettype none

package btxq_pkg;

    localparam int KEY_BITS_DEF   = 20;
    localparam int NODES_DEF      = 4096;
    localparam int COUNT_BITS_DEF = 24;

    localparam int OP_W     = 3;
    localparam int AMT_W    = 25;
    localparam int VALUE_W  = 24;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE = 3'd1;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd2;
    localparam logic [OP_W-1:0] OP_XMIN  = 3'd3;
    localparam logic [OP_W-1:0] OP_XMAX  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POOL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 24'hFFFFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_WRD,
        S_WDAT,
        S_CHECK,
        S_ALLOC,
        S_ADAT,
        S_AINIT,
        S_ALINK,
        S_ARD,
        S_AUPD,
        S_ERD,
        S_EDAT,
        S_EUNL,
        S_EEND,
        S_FIN
    } ctl_state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,
        CMD_DISP,
        CMD_WALK,
        CMD_CHECK,
        CMD_ALLOC,
        CMD_ALLOC_DAT,
        CMD_INIT,
        CMD_LINK,
        CMD_AUPD,
        CMD_ERASE,
        CMD_UNLINK,
        CMD_EEND,
        CMD_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            root_abs;
        logic            at_leaf;
        logic            child_abs;
        logic            pool_short;
        logic            overflow;
        logic            free_empty;
        logic            alloc_root;
        logic            start_unlink;
        logic            leaf_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/btxq_ram.sv -----
// ============================================================================
// btxq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
`default_nettype none

module btxq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/btxq_ctrl.sv -----
// ============================================================================
// btxq_ctrl
// Sequencer that steps the datapath through walks, allocation and erase.
// ============================================================================
`default_nettype none

module btxq_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire btxq_pkg::dp_stat_t  stat,
    output btxq_pkg::dp_cmd_t        cmd
);

    btxq_pkg::ctl_state_t state_reg, state_next;
    logic                 mv_reg, mv_next;
    logic                 slot_free;
    logic                 is_xor;

    assign slot_free = !mv_reg || m_ready;
    assign is_xor    = (stat.op == btxq_pkg::OP_XMIN) || (stat.op == btxq_pkg::OP_XMAX);
    assign s_ready   = (state_reg == btxq_pkg::S_IDLE);
    assign m_valid   = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= btxq_pkg::S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            btxq_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = btxq_pkg::S_DISP;
                end
            end
            btxq_pkg::S_DISP: begin
                if (stat.op > btxq_pkg::OP_XMAX) begin
                    state_next = btxq_pkg::S_FIN;
                end else if (stat.root_abs) begin
                    state_next = (stat.op == btxq_pkg::OP_ADD) ? btxq_pkg::S_CHECK
                                                               : btxq_pkg::S_FIN;
                end else begin
                    state_next = btxq_pkg::S_WRD;
                end
            end
            btxq_pkg::S_WRD: state_next = btxq_pkg::S_WDAT;
            btxq_pkg::S_WDAT: begin
                if (stat.at_leaf) begin
                    if (stat.op == btxq_pkg::OP_ADD) begin
                        state_next = btxq_pkg::S_CHECK;
                    end else if (stat.op == btxq_pkg::OP_ERASE) begin
                        state_next = btxq_pkg::S_ERD;
                    end else begin
                        state_next = btxq_pkg::S_FIN;
                    end
                end else if (stat.child_abs && !is_xor) begin
                    state_next = (stat.op == btxq_pkg::OP_ADD) ? btxq_pkg::S_CHECK
                                                               : btxq_pkg::S_FIN;
                end else begin
                    state_next = btxq_pkg::S_WRD;
                end
            end
            btxq_pkg::S_CHECK: begin
                if (stat.pool_short || stat.overflow) begin
                    state_next = btxq_pkg::S_FIN;
                end else if (stat.root_abs) begin
                    state_next = btxq_pkg::S_ALLOC;
                end else begin
                    state_next = btxq_pkg::S_ARD;
                end
            end
            btxq_pkg::S_ALLOC: begin
                state_next = stat.free_empty ? btxq_pkg::S_AINIT : btxq_pkg::S_ADAT;
            end
            btxq_pkg::S_ADAT: state_next = btxq_pkg::S_AINIT;
            btxq_pkg::S_AINIT: begin
                state_next = stat.alloc_root ? btxq_pkg::S_ARD : btxq_pkg::S_ALINK;
            end
            btxq_pkg::S_ALINK: state_next = btxq_pkg::S_ARD;
            btxq_pkg::S_ARD:   state_next = btxq_pkg::S_AUPD;
            btxq_pkg::S_AUPD: begin
                if (stat.at_leaf) begin
                    state_next = btxq_pkg::S_FIN;
                end else if (stat.child_abs) begin
                    state_next = btxq_pkg::S_ALLOC;
                end else begin
                    state_next = btxq_pkg::S_ARD;
                end
            end
            btxq_pkg::S_ERD: state_next = btxq_pkg::S_EDAT;
            btxq_pkg::S_EDAT: begin
                if (stat.start_unlink) begin
                    state_next = btxq_pkg::S_EUNL;
                end else if (stat.at_leaf) begin
                    state_next = btxq_pkg::S_EEND;
                end else begin
                    state_next = btxq_pkg::S_ERD;
                end
            end
            btxq_pkg::S_EUNL: begin
                state_next = stat.leaf_done ? btxq_pkg::S_EEND : btxq_pkg::S_ERD;
            end
            btxq_pkg::S_EEND: state_next = btxq_pkg::S_FIN;
            btxq_pkg::S_FIN: begin
                if (slot_free) begin
                    state_next = btxq_pkg::S_IDLE;
                end
            end
            default: state_next = btxq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = btxq_pkg::CMD_NONE;
        mv_next = mv_reg && !m_ready;
        unique case (state_reg)
            btxq_pkg::S_IDLE:  cmd = s_valid ? btxq_pkg::CMD_START : btxq_pkg::CMD_NONE;
            btxq_pkg::S_DISP:  cmd = btxq_pkg::CMD_DISP;
            btxq_pkg::S_WDAT:  cmd = btxq_pkg::CMD_WALK;
            btxq_pkg::S_CHECK: cmd = btxq_pkg::CMD_CHECK;
            btxq_pkg::S_ALLOC: cmd = btxq_pkg::CMD_ALLOC;
            btxq_pkg::S_ADAT:  cmd = btxq_pkg::CMD_ALLOC_DAT;
            btxq_pkg::S_AINIT: cmd = btxq_pkg::CMD_INIT;
            btxq_pkg::S_ALINK: cmd = btxq_pkg::CMD_LINK;
            btxq_pkg::S_AUPD:  cmd = btxq_pkg::CMD_AUPD;
            btxq_pkg::S_EDAT:  cmd = btxq_pkg::CMD_ERASE;
            btxq_pkg::S_EUNL:  cmd = btxq_pkg::CMD_UNLINK;
            btxq_pkg::S_EEND:  cmd = btxq_pkg::CMD_EEND;
            btxq_pkg::S_FIN: begin
                if (slot_free) begin
                    cmd     = btxq_pkg::CMD_OUT;
                    mv_next = 1'b1;
                end
            end
            btxq_pkg::S_WRD, btxq_pkg::S_ARD, btxq_pkg::S_ERD: cmd = btxq_pkg::CMD_NONE;
            default: cmd = btxq_pkg::CMD_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/btxq_dp.sv -----
// ============================================================================
// btxq_dp
// Datapath: node pool, free stack, walk registers and result registers.
// ============================================================================
`default_nettype none

module btxq_dp #(
    parameter int KEY_BITS   = btxq_pkg::KEY_BITS_DEF,
    parameter int NODES      = btxq_pkg::NODES_DEF,
    parameter int COUNT_BITS = btxq_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire btxq_pkg::dp_cmd_t                    cmd,
    output btxq_pkg::dp_stat_t                        stat,
    input  wire logic        [btxq_pkg::OP_W-1:0]     s_op,
    input  wire logic        [KEY_BITS-1:0]           s_key,
    input  wire logic signed [btxq_pkg::AMT_W-1:0]    s_amount,
    output logic             [btxq_pkg::VALUE_W-1:0]  m_value,
    output logic             [btxq_pkg::STATUS_W-1:0] m_status
);

    localparam int IDX_W  = $clog2(NODES);
    localparam int NODE_W = $clog2(NODES + 1);
    localparam int LVL_W  = $clog2(KEY_BITS + 1);
    localparam int NEED_W = $clog2(KEY_BITS + 2);
    localparam int NW     = 2 * NODE_W + COUNT_BITS;
    localparam logic [NODE_W-1:0] ABSENT = NODE_W'(NODES);
    localparam logic [LVL_W-1:0]  TOP    = LVL_W'(KEY_BITS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [btxq_pkg::OP_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0]           key_reg, key_next;
    logic [btxq_pkg::AMT_W-1:0]    amt_reg, amt_next;
    logic [NODE_W-1:0]             p_reg, p_next;
    logic [LVL_W-1:0]              lvl_reg, lvl_next;
    logic [NODE_W-1:0]             root_reg, root_next;
    logic [NODE_W-1:0]             ft_reg, ft_next;
    logic [NODE_W-1:0]             hw_reg, hw_next;
    logic [NEED_W-1:0]             need_reg, need_next;
    logic [COUNT_BITS-1:0]         rcnt_reg, rcnt_next;
    logic [KEY_BITS-1:0]           res_reg, res_next;
    logic [COUNT_BITS-1:0]         num_reg, num_next;
    logic                          full_reg, full_next;
    logic                          frg_reg, frg_next;
    logic [LVL_W-1:0]              flvl_reg, flvl_next;
    logic [IDX_W-1:0]              new_reg, new_next;
    logic                          aroot_reg, aroot_next;
    logic [NODE_W-1:0]             c0_reg, c0_next, c1_reg, c1_next;
    logic [COUNT_BITS-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]              pidx_reg, pidx_next;
    logic [NODE_W-1:0]             pc0_reg, pc0_next, pc1_reg, pc1_next;
    logic [COUNT_BITS-1:0]         pcnt_reg, pcnt_next;
    logic                          leaf_reg, leaf_next;
    logic [btxq_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic [btxq_pkg::STATUS_W-1:0] sts_reg, sts_next;
    logic [btxq_pkg::VALUE_W-1:0]  mval_reg, mval_next;
    logic [btxq_pkg::STATUS_W-1:0] msts_reg, msts_next;

    logic              nd_we;
    logic [IDX_W-1:0]  nd_waddr;
    logic [NW-1:0]     nd_wdata, nd_rdata;
    logic              fs_we;
    logic [IDX_W-1:0]  fs_waddr, fs_wdata, fs_raddr, fs_rdata;

    logic                  p_abs, root_abs, at_leaf;
    logic [NODE_W-1:0]     nd_c0, nd_c1, child, xkid, xnext;
    logic [COUNT_BITS-1:0] nd_cnt;
    logic [LVL_W-1:0]      lvl_m1;
    logic [KEY_BITS-1:0]   key_sh, ukey_sh;
    logic                  key_bit, ubit, child_abs, want_max, xb0, xb;
    logic [KEY_BITS:0]     res_sh;
    logic [32:0]           cnt_ext, amt_ext, xor_ext;
    logic [btxq_pkg::VALUE_W-1:0] cnt_sat;
    logic                  full_now, pool_short, overflow, start_unlink;
    logic [NODE_W:0]       avail;
    logic [NODE_W-1:0]     new_ext;

    btxq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (p_reg[IDX_W-1:0]),
        .rdata (nd_rdata)
    );

    btxq_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_free_ram (
        .aclk  (aclk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    assign fs_raddr = IDX_W'(ft_reg - 1'b1);
    assign p_abs    = (p_reg >= ABSENT);
    assign root_abs = (root_reg >= ABSENT);
    assign at_leaf  = (lvl_reg == '0);
    assign nd_c1    = p_abs ? ABSENT : nd_rdata[NW-1 -: NODE_W];
    assign nd_c0    = p_abs ? ABSENT : nd_rdata[COUNT_BITS +: NODE_W];
    assign nd_cnt   = p_abs ? '0 : nd_rdata[COUNT_BITS-1:0];
    assign lvl_m1   = lvl_reg - 1'b1;
    assign key_sh   = key_reg >> lvl_m1;
    assign key_bit  = key_sh[0];
    assign ukey_sh  = key_reg >> flvl_reg;
    assign ubit     = ukey_sh[0];
    assign child    = key_bit ? nd_c1 : nd_c0;
    assign child_abs = (child >= ABSENT);
    assign want_max = (op_reg == btxq_pkg::OP_XMAX);
    assign xb0      = key_bit ^ want_max;
    assign xkid     = xb0 ? nd_c1 : nd_c0;
    assign xb       = (xkid >= ABSENT) ? ~xb0 : xb0;
    assign xnext    = xb ? nd_c1 : nd_c0;
    assign res_sh   = {res_reg, xb};
    assign cnt_ext  = 33'(nd_cnt);
    assign amt_ext  = 33'(amt_reg[btxq_pkg::VALUE_W-1:0]);
    assign xor_ext  = 33'(key_reg ^ res_reg);
    assign cnt_sat  = (cnt_ext > 33'(btxq_pkg::VALUE_MAX)) ? btxq_pkg::VALUE_MAX
                                                           : cnt_ext[btxq_pkg::VALUE_W-1:0];
    assign full_now = amt_reg[btxq_pkg::AMT_W-1] || (amt_ext >= cnt_ext);
    assign avail    = (NODE_W+1)'(ft_reg) + (NODE_W+1)'(ABSENT - hw_reg);
    assign pool_short = ((NODE_W+1)'(need_reg) > avail);
    assign overflow = !root_abs && (rcnt_reg == CNT_MAX);
    assign start_unlink = full_reg && !frg_reg && (nd_cnt == num_reg) && (lvl_reg != TOP);
    assign new_ext  = NODE_W'(new_reg);

    assign stat.op           = op_reg;
    assign stat.root_abs     = root_abs;
    assign stat.at_leaf      = at_leaf;
    assign stat.child_abs    = child_abs;
    assign stat.pool_short   = pool_short;
    assign stat.overflow     = overflow;
    assign stat.free_empty   = (ft_reg == '0);
    assign stat.alloc_root   = aroot_reg;
    assign stat.start_unlink = start_unlink;
    assign stat.leaf_done    = leaf_reg;

    assign m_value  = mval_reg;
    assign m_status = msts_reg;

    always_comb begin
        op_next = op_reg;       key_next = key_reg;     amt_next = amt_reg;
        p_next = p_reg;         lvl_next = lvl_reg;     root_next = root_reg;
        ft_next = ft_reg;       hw_next = hw_reg;       need_next = need_reg;
        rcnt_next = rcnt_reg;   res_next = res_reg;     num_next = num_reg;
        full_next = full_reg;   frg_next = frg_reg;     flvl_next = flvl_reg;
        new_next = new_reg;     aroot_next = aroot_reg;
        c0_next = c0_reg;       c1_next = c1_reg;       cnt_next = cnt_reg;
        pidx_next = pidx_reg;   pc0_next = pc0_reg;     pc1_next = pc1_reg;
        pcnt_next = pcnt_reg;   leaf_next = leaf_reg;
        val_next = val_reg;     sts_next = sts_reg;
        mval_next = mval_reg;   msts_next = msts_reg;
        nd_we = 1'b0;
        nd_waddr = p_reg[IDX_W-1:0];
        nd_wdata = {nd_c1, nd_c0, COUNT_BITS'(nd_cnt + 1'b1)};
        fs_we = 1'b0;
        fs_waddr = IDX_W'(ft_reg + NODE_W'(lvl_reg));
        fs_wdata = p_reg[IDX_W-1:0];

        unique case (cmd)
            btxq_pkg::CMD_START: begin
                op_next    = s_op;
                key_next   = s_key;
                amt_next   = s_amount;
                p_next     = root_reg;
                lvl_next   = TOP;
                res_next   = '0;
                val_next   = '0;
                sts_next   = btxq_pkg::ST_OK;
                frg_next   = 1'b0;
                aroot_next = 1'b0;
            end
            btxq_pkg::CMD_DISP: begin
                if (root_abs) begin
                    if (op_reg == btxq_pkg::OP_XMIN || op_reg == btxq_pkg::OP_XMAX) begin
                        sts_next = btxq_pkg::ST_EMPTY;
                    end
                    need_next = NEED_W'(KEY_BITS + 1);
                end
            end
            btxq_pkg::CMD_WALK: begin
                if (at_leaf) begin
                    need_next = '0;
                    p_next    = root_reg;
                    lvl_next  = TOP;
                    if (op_reg == btxq_pkg::OP_COUNT) begin
                        val_next = cnt_sat;
                    end else if (op_reg == btxq_pkg::OP_XMIN || op_reg == btxq_pkg::OP_XMAX) begin
                        val_next = xor_ext[btxq_pkg::VALUE_W-1:0];
                    end else if (op_reg == btxq_pkg::OP_ERASE) begin
                        full_next = full_now;
                        num_next  = full_now ? nd_cnt : COUNT_BITS'(amt_ext);
                        val_next  = full_now ? cnt_sat : amt_ext[btxq_pkg::VALUE_W-1:0];
                    end
                end else begin
                    if (lvl_reg == TOP) begin
                        rcnt_next = nd_cnt;
                    end
                    if (op_reg == btxq_pkg::OP_XMIN || op_reg == btxq_pkg::OP_XMAX) begin
                        p_next   = xnext;
                        res_next = res_sh[KEY_BITS-1:0];
                        lvl_next = lvl_m1;
                    end else if (child_abs) begin
                        need_next = NEED_W'(lvl_reg);
                    end else begin
                        p_next   = child;
                        lvl_next = lvl_m1;
                    end
                end
            end
            btxq_pkg::CMD_CHECK: begin
                if (pool_short) begin
                    sts_next = btxq_pkg::ST_POOL;
                end else if (overflow) begin
                    sts_next = btxq_pkg::ST_OVF;
                end else begin
                    p_next     = root_reg;
                    lvl_next   = TOP;
                    aroot_next = root_abs;
                end
            end
            btxq_pkg::CMD_ALLOC: begin
                if (ft_reg != '0) begin
                    ft_next = ft_reg - 1'b1;
                end else begin
                    new_next = hw_reg[IDX_W-1:0];
                    hw_next  = hw_reg + 1'b1;
                end
            end
            btxq_pkg::CMD_ALLOC_DAT: begin
                new_next = fs_rdata;
            end
            btxq_pkg::CMD_INIT: begin
                nd_we    = 1'b1;
                nd_waddr = new_reg;
                nd_wdata = {ABSENT, ABSENT, {COUNT_BITS{1'b0}}};
                if (aroot_reg) begin
                    root_next  = new_ext;
                    p_next     = new_ext;
                    aroot_next = 1'b0;
                end
            end
            btxq_pkg::CMD_LINK: begin
                nd_we    = 1'b1;
                nd_wdata = {key_bit ? new_ext : c1_reg, key_bit ? c0_reg : new_ext,
                            COUNT_BITS'(cnt_reg + 1'b1)};
                p_next   = new_ext;
                lvl_next = lvl_m1;
            end
            btxq_pkg::CMD_AUPD: begin
                c0_next  = nd_c0;
                c1_next  = nd_c1;
                cnt_next = nd_cnt;
                if (at_leaf) begin
                    nd_we = 1'b1;
                end else if (!child_abs) begin
                    nd_we    = 1'b1;
                    p_next   = child;
                    lvl_next = lvl_m1;
                end
            end
            btxq_pkg::CMD_ERASE: begin
                if (frg_reg) begin
                    fs_we = 1'b1;
                end else if (full_reg && nd_cnt == num_reg) begin
                    fs_we     = 1'b1;
                    frg_next  = 1'b1;
                    flvl_next = lvl_reg;
                    if (lvl_reg == TOP) begin
                        root_next = ABSENT;
                    end
                end else begin
                    nd_we     = 1'b1;
                    nd_wdata  = {nd_c1, nd_c0, COUNT_BITS'(nd_cnt - num_reg)};
                    pidx_next = p_reg[IDX_W-1:0];
                    pc0_next  = nd_c0;
                    pc1_next  = nd_c1;
                    pcnt_next = COUNT_BITS'(nd_cnt - num_reg);
                end
                leaf_next = at_leaf;
                if (!at_leaf) begin
                    p_next   = child;
                    lvl_next = lvl_m1;
                end
            end
            btxq_pkg::CMD_UNLINK: begin
                nd_we    = 1'b1;
                nd_waddr = pidx_reg;
                nd_wdata = {ubit ? ABSENT : pc1_reg, ubit ? pc0_reg : ABSENT, pcnt_reg};
            end
            btxq_pkg::CMD_EEND: begin
                if (frg_reg) begin
                    ft_next = ft_reg + NODE_W'(flvl_reg) + 1'b1;
                end
            end
            btxq_pkg::CMD_OUT: begin
                mval_next = val_reg;
                msts_next = sts_reg;
            end
            btxq_pkg::CMD_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= ABSENT;
            ft_reg   <= '0;
            hw_reg   <= '0;
        end else begin
            root_reg <= root_next;
            ft_reg   <= ft_next;
            hw_reg   <= hw_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;    key_reg  <= key_next;   amt_reg   <= amt_next;
        p_reg    <= p_next;     lvl_reg  <= lvl_next;   need_reg  <= need_next;
        rcnt_reg <= rcnt_next;  res_reg  <= res_next;   num_reg   <= num_next;
        full_reg <= full_next;  frg_reg  <= frg_next;   flvl_reg  <= flvl_next;
        new_reg  <= new_next;   aroot_reg <= aroot_next;
        c0_reg   <= c0_next;    c1_reg   <= c1_next;    cnt_reg   <= cnt_next;
        pidx_reg <= pidx_next;  pc0_reg  <= pc0_next;   pc1_reg   <= pc1_next;
        pcnt_reg <= pcnt_next;  leaf_reg <= leaf_next;
        val_reg  <= val_next;   sts_reg  <= sts_next;
        mval_reg <= mval_next;  msts_reg <= msts_next;
    end

endmodule

`default_nettype wire

// ----- hdl/binary_trie_multiset_xor_query.sv -----
// ============================================================================
// binary_trie_multiset_xor_query
// Multiset of keys held as a fixed-depth binary trie with add, erase, count
// and XOR minimum/maximum queries.
// ============================================================================
//  Channel   Direction  Ports                               Transfer when
//  request   in         s_op, s_key, s_amount               s_valid && s_ready
//  result    out        m_value, m_status                   m_valid && m_ready
//
//  One request is worked on at a time; each trie level waits for the node
//  memory's registered read. Erase takes an extra unlink step when a link
//  is cleared, and add an extra read step for each node that is taken from
//  the free stack rather than from the unused part of the pool.
//  Reset is synchronous and active low; the node pool needs no clearing pass.
//  A finished result waits in the output register while the next request is
//  taken; the block stalls only if a second result is ready before that.
// ============================================================================
`default_nettype none

module binary_trie_multiset_xor_query #(
    parameter int KEY_BITS   = btxq_pkg::KEY_BITS_DEF,
    parameter int NODES      = btxq_pkg::NODES_DEF,
    parameter int COUNT_BITS = btxq_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic        [btxq_pkg::OP_W-1:0]     s_op,
    input  wire logic        [KEY_BITS-1:0]           s_key,
    input  wire logic signed [btxq_pkg::AMT_W-1:0]    s_amount,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [btxq_pkg::VALUE_W-1:0]  m_value,
    output logic             [btxq_pkg::STATUS_W-1:0] m_status
);

    btxq_pkg::dp_cmd_t  cmd;
    btxq_pkg::dp_stat_t stat;

    btxq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    btxq_dp #(
        .KEY_BITS   (KEY_BITS),
        .NODES      (NODES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_op     (s_op),
        .s_key    (s_key),
        .s_amount (s_amount),
        .m_value  (m_value),
        .m_status (m_status)
    );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the binary trie multiset: a scoreboard keeps its own
// trie and predicts each result of add, erase, count and XOR min/max requests.
// ============================================================================
`default_nettype none

module tb_top;

    localparam int KB = btxq_pkg::KEY_BITS_DEF;
    localparam int NN = btxq_pkg::NODES_DEF;
    localparam int CMAX = (1 << btxq_pkg::COUNT_BITS_DEF) - 1;

    typedef struct packed {
        logic [btxq_pkg::OP_W-1:0]         op;
        logic [KB-1:0]                     key;
        logic signed [btxq_pkg::AMT_W-1:0] amount;
    } request_t;

    typedef struct packed {
        logic [btxq_pkg::VALUE_W-1:0]  value;
        logic [btxq_pkg::STATUS_W-1:0] status;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [btxq_pkg::OP_W-1:0] s_op = '0;
    logic [KB-1:0] s_key = '0;
    logic signed [btxq_pkg::AMT_W-1:0] s_amount = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [btxq_pkg::VALUE_W-1:0] m_value;
    logic [btxq_pkg::STATUS_W-1:0] m_status;

    binary_trie_multiset_xor_query u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .s_key(s_key), .s_amount(s_amount),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_value), .m_status(m_status)
    );

    // Shadow trie.
    int zero_link[NN];
    int one_link[NN];
    longint copies[NN];
    int free_list[NN];
    int free_depth = 0;
    int fresh_next = 0;
    int root = NN;

    request_t pending_reqs[$];
    answer_t expected_answers[$];
    int mismatches = 0;
    int key_pool[$];
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit holding = 1'b0;

    function automatic int link_of(int p, int b);
        if (p >= NN) return NN;
        return b ? one_link[p] : zero_link[p];
    endfunction

    function automatic void set_link(int p, int b, int c);
        if (p >= NN) return;
        if (b) one_link[p] = c; else zero_link[p] = c;
    endfunction

    function automatic int grab_node();
        int n;
        if (free_depth > 0) begin
            free_depth--;
            n = free_list[free_depth];
        end else begin
            n = fresh_next++;
        end
        if (n >= NN) return NN;
        copies[n] = 0;
        zero_link[n] = NN;
        one_link[n] = NN;
        return n;
    endfunction

    function automatic answer_t trie_apply(request_t r);
        answer_t a;
        int p;
        int k;
        int b;
        int n;
        int needed;
        int avail;
        int path[KB+1];
        longint num;
        longint leaf;
        logic [KB-1:0] res;
        a.value = '0;
        a.status = btxq_pkg::ST_OK;
        case (r.op)
            btxq_pkg::OP_ADD: begin
                needed = 0;
                if (root >= NN) begin
                    needed = KB + 1;
                end else begin
                    p = root;
                    for (k = KB - 1; k >= 0; k--) begin
                        p = link_of(p, r.key[k]);
                        if (p >= NN) begin
                            needed = k + 1;
                            break;
                        end
                    end
                end
                avail = free_depth + (fresh_next < NN ? NN - fresh_next : 0);
                if (needed > avail) begin
                    a.status = btxq_pkg::ST_POOL;
                end else if (root < NN && copies[root] >= CMAX) begin
                    a.status = btxq_pkg::ST_OVF;
                end else begin
                    if (root >= NN) root = grab_node();
                    p = root;
                    if (p < NN) copies[p]++;
                    for (k = KB - 1; k >= 0; k--) begin
                        n = link_of(p, r.key[k]);
                        if (n >= NN) begin
                            n = grab_node();
                            set_link(p, r.key[k], n);
                        end
                        p = n;
                        if (p < NN) copies[p]++;
                    end
                end
            end
            btxq_pkg::OP_ERASE: begin
                p = root;
                if (p >= NN) return a;
                path[KB] = p;
                for (k = KB - 1; k >= 0; k--) begin
                    p = link_of(p, r.key[k]);
                    if (p >= NN) return a;
                    path[k] = p;
                end
                leaf = copies[p];
                num = longint'(r.amount[23:0]);
                if (!r.amount[24] && num < leaf) begin
                    for (k = 0; k <= KB; k++) copies[path[k]] -= num;
                    a.value = num[23:0];
                    return a;
                end
                num = leaf;
                k = 0;
                while (k <= KB && copies[path[k]] == num) begin
                    if (free_depth < NN) free_list[free_depth++] = path[k];
                    k++;
                end
                if (k == KB + 1) begin
                    root = NN;
                end else begin
                    if (k > 0) set_link(path[k], r.key[k-1], NN);
                    for (; k <= KB; k++) copies[path[k]] -= num;
                end
                a.value = (num > CMAX) ? btxq_pkg::VALUE_MAX : num[23:0];
            end
            btxq_pkg::OP_COUNT: begin
                p = root;
                if (p >= NN) return a;
                for (k = KB - 1; k >= 0; k--) begin
                    p = link_of(p, r.key[k]);
                    if (p >= NN) return a;
                end
                a.value = copies[p][23:0];
            end
            btxq_pkg::OP_XMIN, btxq_pkg::OP_XMAX: begin
                p = root;
                if (p >= NN) begin
                    a.status = btxq_pkg::ST_EMPTY;
                    return a;
                end
                res = '0;
                for (k = KB - 1; k >= 0; k--) begin
                    b = r.key[k] ^ (r.op == btxq_pkg::OP_XMAX);
                    if (link_of(p, b) >= NN) b ^= 1;
                    p = link_of(p, b);
                    res[k] = b[0];
                end
                a.value = btxq_pkg::VALUE_W'(r.key ^ res);
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [KB-1:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return KB'(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        return KB'($urandom);
    endfunction

    task automatic push_req(logic [btxq_pkg::OP_W-1:0] op, logic [KB-1:0] key,
                            logic signed [btxq_pkg::AMT_W-1:0] amount);
        request_t r;
        r.op = op;
        r.key = key;
        r.amount = amount;
        pending_reqs.push_back(r);
    endtask

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Input monitor: a request transfer is predicted at the edge it happens.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_answers.push_back(trie_apply({s_op, s_key, s_amount}));
            in_taken = 1'b1;
        end
    end

    // Driver.
    int send_gap = 0;
    always @(negedge aclk) begin
        request_t r;
        if (aresetn) begin
            if (in_taken) begin
                in_taken = 1'b0;
                holding = 1'b0;
                send_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    s_op <= r.op;
                    s_key <= r.key;
                    s_amount <= r.amount;
                    holding = 1'b1;
                end
            end
            s_valid <= holding;
        end
    end

    // Result side: ready changes at the falling edge, sampling at the rising edge.
    int take_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken) begin
                out_taken = 1'b0;
                take_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) take_gap = 0;
            end
            if (take_gap > 0) begin
                take_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            out_taken = 1'b1;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer value=%0h status=%0d",
                             m_value, m_status);
            end else begin
                want = expected_answers.pop_front();
                if (want.value !== m_value || want.status !== m_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected value=%0h status=%0d,",
                                  " got value=%0h status=%0d"},
                                 want.value, want.status, m_value, m_status);
                end
            end
        end
    end

    initial begin
        int i;
        int j;
        int sel;
        logic [KB-1:0] key;
        for (i = 0; i < NN; i++) begin
            zero_link[i] = 0;
            one_link[i] = 0;
            copies[i] = 0;
            free_list[i] = 0;
        end

        // Directed part: empty-set cases, extremes, all op codes.
        push_req(btxq_pkg::OP_XMIN, '0, '0);
        push_req(btxq_pkg::OP_XMAX, '1, '0);
        push_req(btxq_pkg::OP_COUNT, '1, '0);
        push_req(btxq_pkg::OP_ERASE, '0, -1);
        push_req(btxq_pkg::OP_ADD, '0, '0);
        push_req(btxq_pkg::OP_ADD, '1, '0);
        push_req(btxq_pkg::OP_ADD, '1, '1);
        push_req(btxq_pkg::OP_ADD, 20'h55555, '0);
        push_req(btxq_pkg::OP_COUNT, '1, '0);
        push_req(btxq_pkg::OP_XMIN, 20'h55554, '0);
        push_req(btxq_pkg::OP_XMAX, 20'h55555, '0);
        push_req(btxq_pkg::OP_ERASE, '1, 25'd0);
        push_req(btxq_pkg::OP_ERASE, '1, 25'd1);
        push_req(btxq_pkg::OP_ERASE, '1, 25'hFFFFFF);
        push_req(btxq_pkg::OP_ERASE, 20'h12345, -1);
        push_req(btxq_pkg::OP_ERASE, 20'h55555, 25'h1000000);
        push_req(3'd5, 20'hAAAAA, 25'h0AAAAAA);
        push_req(3'd6, '0, '0);
        push_req(3'd7, '1, '1);
        push_req(btxq_pkg::OP_XMIN, 20'hFFFFF, '0);
        push_req(btxq_pkg::OP_ERASE, '0, -1);
        push_req(btxq_pkg::OP_XMAX, '0, '0);

        // Random part: many adds on a reused key pool to grow the trie, mixed with
        // erases, counts and XOR queries, and one sweep that fills the node pool.
        for (i = 0; i < 1390; i++) begin
            if (i % 400 == 0) begin
                key_pool.delete();
                for (j = 0; j < 12 + (i / 100); j++) key_pool.push_back($urandom);
            end
            sel = $urandom_range(0, 99);
            key = pick_key();
            if (sel < 40) push_req(btxq_pkg::OP_ADD, key, btxq_pkg::AMT_W'($urandom));
            else if (sel < 55) begin
                case ($urandom_range(0, 3))
                    0: push_req(btxq_pkg::OP_ERASE, key, -1);
                    1: push_req(btxq_pkg::OP_ERASE, key,
                                btxq_pkg::AMT_W'($urandom_range(0, 3)));
                    2: push_req(btxq_pkg::OP_ERASE, key, btxq_pkg::AMT_W'($urandom));
                    default: push_req(btxq_pkg::OP_ERASE, key,
                                      btxq_pkg::AMT_W'($urandom_range(0, 1)));
                endcase
            end
            else if (sel < 70) push_req(btxq_pkg::OP_COUNT, key, btxq_pkg::AMT_W'($urandom));
            else if (sel < 83) push_req(btxq_pkg::OP_XMIN, KB'($urandom),
                                        btxq_pkg::AMT_W'($urandom));
            else if (sel < 96) push_req(btxq_pkg::OP_XMAX, KB'($urandom),
                                        btxq_pkg::AMT_W'($urandom));
            else push_req(btxq_pkg::OP_W'($urandom_range(5, 7)), KB'($urandom),
                          btxq_pkg::AMT_W'($urandom));
            // Mid-run: exhaust the node pool with spread-out keys, then query XOR max.
            if (i == 800) begin
                for (j = 0; j < 240; j++) push_req(btxq_pkg::OP_ADD, KB'($urandom), '0);
                push_req(btxq_pkg::OP_XMAX, '0, '0);
            end
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() > 0 || s_valid) @(posedge aclk);
        while (expected_answers.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
